[design/ritoa_pkg.sv]
// ----------------------------------------------------------------------------
// ritoa_pkg: shared types and constants for the radix integer to ascii block
// Field widths, radix limits, ascii codes and the digit mapping helpers.
// ----------------------------------------------------------------------------
package ritoa_pkg;

  localparam int VALUE_W = 32;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam radix_t RADIX_MIN     = 6'd2;
  localparam radix_t RADIX_MAX     = 6'd36;
  localparam digit_t DECIMAL_LIMIT = 6'd10;
  localparam char_t  CHAR_ZERO     = 7'h30;
  localparam char_t  CHAR_LOWER_A  = 7'h61;

  function automatic radix_t sat_radix(radix_t r);
    radix_t res;
    if (r inside {[RADIX_MIN:RADIX_MAX]}) begin
      res = r;
    end else if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic char_t digit_to_ascii(digit_t d);
    char_t res;
    if (d < DECIMAL_LIMIT) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_LOWER_A + {1'b0, d - DECIMAL_LIMIT};
    end
    return res;
  endfunction

endpackage

[design/radix_integer_to_ascii_top.sv]
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top: unsigned integer to ascii digits in radix 2..36
// Converts one value per input beat into a string of digit characters.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes value_i and radix_i; radix is clamped to 2..36.
//   The output channel returns one beat per digit character, most significant
//   first, with last_digit_o set on the least significant character.
//   A value of zero gives the single character '0'.
//   Digits come from a restoring divider, one quotient bit per cycle, shared
//   over all digits: each digit is one full division of the running quotient
//   by the radix. Characters are then read back from the digit store, one at
//   a time, through a read state and a send state.
//   in_stall_o stays high from acceptance until the last character is taken.
//   A stall on the output holds the current character and pauses the readout.
//   Reset returns the block to idle with no output beat pending.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ritoa_pkg::value_t value_i,
  input  ritoa_pkg::radix_t radix_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ritoa_pkg::char_t  char_code_o,
  output logic              last_digit_o
);
  import ritoa_pkg::*;

  localparam int IDXW  = $clog2(VALUE_BITS);
  localparam int CNTW  = $clog2(VALUE_BITS + 1);
  localparam int LOADW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  typedef logic [VALUE_BITS-1:0] quot_t;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0]      state_q, state_d;
  quot_t           quot_q, quot_d;
  digit_t          rem_q, rem_d;
  radix_t          radix_q, radix_d;
  logic [IDXW-1:0] bit_cnt_q, bit_cnt_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic            mem_we;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             ge;
  digit_t           rem_next;
  quot_t            quot_next;
  logic             bit_last;

  digit_t digit_mem [VALUE_BITS];
  digit_t rd_data_q;

  // shared divide step: one quotient bit per cycle
  always_comb begin
    trial     = {rem_q, quot_q[VALUE_BITS-1]};
    diff      = trial - {1'b0, radix_q};
    ge        = trial >= {1'b0, radix_q};
    rem_next  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    quot_next = {quot_q[VALUE_BITS-2:0], ge};
    bit_last  = bit_cnt_q == IDXW'(VALUE_BITS - 1);
  end

  always_comb begin
    state_d   = state_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    bit_cnt_d = bit_cnt_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    mem_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          quot_d    = quot_t'(value_i[LOADW-1:0]);
          radix_d   = sat_radix(radix_i);
          rem_d     = '0;
          bit_cnt_d = '0;
          cnt_d     = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_d    = quot_next;
        rem_d     = rem_next;
        bit_cnt_d = IDXW'(bit_cnt_q + 1'b1);
        if (bit_last) begin
          mem_we    = 1'b1;
          bit_cnt_d = '0;
          rem_d     = '0;
          cnt_d     = CNTW'(cnt_q + 1'b1);
          if (quot_next == '0 || cnt_q == CNTW'(VALUE_BITS - 1)) begin
            idx_d   = cnt_q[IDXW-1:0];
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall_i) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = IDXW'(idx_q - 1'b1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
  end

  // digit store, least significant digit at index zero
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[IDXW-1:0]] <= rem_next;
    end
    rd_data_q <= digit_mem[idx_q];
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = state_q == ST_SEND;
  assign char_code_o  = digit_to_ascii(rd_data_q);
  assign last_digit_o = idx_q == '0;

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < radix_q))
    else $error("partial remainder not below radix");

  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (radix_q >= RADIX_MIN && radix_q <= RADIX_MAX))
    else $error("radix outside clamped range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(VALUE_BITS))
    else $error("digit count beyond store depth");

  a_last_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_digit_o) |=> (state_q == ST_IDLE))
    else $error("block not idle after last beat");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DIV && bit_cnt_q == '0))
    else $error("accepted beat did not start division");

endmodule

[verif/tb_radix_integer_to_ascii_top.sv]
// ----------------------------------------------------------------------------
// tb_radix_integer_to_ascii_top: self-checking bench for radix integer to ascii
// A queue-fed driver sends value/radix beats in random bursts while the output
// side stalls in changing patterns. Every accepted input is turned into its
// expected digit characters, which the monitor checks in order. A directed
// set covers zero, the field extremes and radix clamping. A random set follows
// that leans on small magnitudes, radix power boundaries and clamped radixes.
// ----------------------------------------------------------------------------
module tb_radix_integer_to_ascii_top;

  localparam int NUM_RANDOM     = 450;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct {
    ritoa_pkg::value_t value;
    ritoa_pkg::radix_t radix;
  } conv_req_t;

  typedef struct {
    ritoa_pkg::char_t code;
    logic             last;
  } char_beat_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  ritoa_pkg::value_t value_i      = '0;
  ritoa_pkg::radix_t radix_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  ritoa_pkg::char_t  char_code_o;
  logic              last_digit_o;

  conv_req_t  pending_reqs[$];
  char_beat_t char_expect_q[$];
  int         fail_count  = 0;
  int         gap_left    = 0;
  int         burst_left  = 0;
  int         stall_mode  = 0;
  int         stall_left  = 0;
  int         idle_cycles = 0;

  radix_integer_to_ascii_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_o  (char_code_o),
    .last_digit_o (last_digit_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int clamp_base(ritoa_pkg::radix_t r);
    if (r < ritoa_pkg::RADIX_MIN) return 2;
    if (r > ritoa_pkg::RADIX_MAX) return 36;
    return int'(r);
  endfunction

  // queue the characters of one conversion, most significant digit first
  function automatic void predict_digits(ritoa_pkg::value_t v, ritoa_pkg::radix_t r);
    ritoa_pkg::digit_t digits[32];
    int                n;
    int                base;
    longint unsigned   quot;
    char_beat_t        beat;
    base = clamp_base(r);
    quot = v;
    n    = 0;
    do begin
      digits[n] = ritoa_pkg::digit_t'(quot % base);
      n++;
      quot = quot / base;
    end while (quot != 0 && n < 32);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < ritoa_pkg::DECIMAL_LIMIT) begin
        beat.code = ritoa_pkg::CHAR_ZERO + digits[k];
      end else begin
        beat.code = ritoa_pkg::CHAR_LOWER_A + (digits[k] - ritoa_pkg::DECIMAL_LIMIT);
      end
      beat.last = (k == 0);
      char_expect_q.push_back(beat);
    end
  endfunction

  function automatic ritoa_pkg::radix_t pick_radix();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 72) return ritoa_pkg::radix_t'($urandom_range(36, 2));
    if (sel < 82) return ritoa_pkg::radix_t'($urandom_range(63, 37));
    if (sel < 86) return ritoa_pkg::radix_t'($urandom_range(1, 0));
    return $urandom_range(1, 0) ? ritoa_pkg::RADIX_MIN : ritoa_pkg::RADIX_MAX;
  endfunction

  function automatic ritoa_pkg::value_t pick_value(int base);
    int              sel;
    int              k;
    longint unsigned pw;
    sel = $urandom_range(99, 0);
    if (sel < 40) return $urandom;
    if (sel < 70) return $urandom >> $urandom_range(31, 1);
    if (sel < 85) begin
      pw = 1;
      k  = $urandom_range(31, 0);
      while (k > 0 && pw * base <= 64'hffff_ffff) begin
        pw = pw * base;
        k--;
      end
      return $urandom_range(1, 0) ? ritoa_pkg::value_t'(pw) : ritoa_pkg::value_t'(pw - 1);
    end
    if (sel < 92) return 32'd1 << $urandom_range(31, 0);
    case ($urandom_range(2, 0))
      0:       return '0;
      1:       return 32'd1;
      default: return '1;
    endcase
  endfunction

  // input driver: bursts of beats separated by random gaps
  always @(posedge clk_i) begin : drive_inputs
    conv_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        predict_digits(value_i, radix_i);
      end
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        value_i    <= req.value;
        radix_i    <= req.radix;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left   <= ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(80, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor and stall pattern
  always @(posedge clk_i) begin : check_outputs
    char_beat_t exp_beat;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (char_expect_q.size() == 0) begin
          $error("unexpected beat: char_code %0h last_digit %0b", char_code_o, last_digit_o);
          fail_count++;
        end else begin
          exp_beat = char_expect_q.pop_front();
          if (char_code_o !== exp_beat.code) begin
            $error("char_code expected %0h actual %0h", exp_beat.code, char_code_o);
            fail_count++;
          end
          if (last_digit_o !== exp_beat.last) begin
            $error("last_digit expected %0b actual %0b", exp_beat.last, last_digit_o);
            fail_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(3, 0);
        stall_left <= $urandom_range(60, 1);
        out_stall_i <= 1'b0;
      end else begin
        stall_left <= stall_left - 1;
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(3, 0) == 0);
          2:       out_stall_i <= ($urandom_range(3, 0) != 0);
          default: out_stall_i <= (stall_left < 40);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("radix_integer_to_ascii_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    ritoa_pkg::radix_t r;
    pending_reqs.push_back('{32'd0,          6'd10});
    pending_reqs.push_back('{32'd0,          6'd0});
    pending_reqs.push_back('{32'd1,          6'd1});
    pending_reqs.push_back('{32'hffff_ffff,  6'd2});
    pending_reqs.push_back('{32'hffff_ffff,  6'd36});
    pending_reqs.push_back('{32'hffff_ffff,  6'd63});
    pending_reqs.push_back('{32'hffff_ffff,  6'd16});
    pending_reqs.push_back('{32'hffff_ffff,  6'd10});
    pending_reqs.push_back('{32'd35,         6'd36});
    pending_reqs.push_back('{32'd36,         6'd36});
    pending_reqs.push_back('{32'd9,          6'd10});
    pending_reqs.push_back('{32'd10,         6'd10});
    pending_reqs.push_back('{32'd10,         6'd11});
    pending_reqs.push_back('{32'd255,        6'd16});
    pending_reqs.push_back('{32'd256,        6'd16});
    pending_reqs.push_back('{32'd12345678,   6'd37});
    pending_reqs.push_back('{32'hdead_beef,  6'd16});
    pending_reqs.push_back('{32'h8000_0000,  6'd2});
    pending_reqs.push_back('{32'd1,          6'd2});
    pending_reqs.push_back('{32'h7fff_ffff,  6'd8});
    pending_reqs.push_back('{32'haaaa_aaaa,  6'd21});
    pending_reqs.push_back('{32'h5555_5555,  6'd42});
    pending_reqs.push_back('{32'd1295,       6'd36});
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = pick_radix();
      pending_reqs.push_back('{pick_value(clamp_base(r)), r});
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || char_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("radix_integer_to_ascii_top regression: pass");
    end else begin
      $display("radix_integer_to_ascii_top regression: fail");
    end
    $finish;
  end

endmodule
